[sv/pafc_pkg.sv]
// ----------------------------------------------------------------------------
// pafc_pkg
// Shared types and constants for the pyro arm/fire controller.
// ----------------------------------------------------------------------------
package pafc_pkg;

	localparam int NUM_CHANNELS = 5;
	localparam int CH_W         = $clog2(NUM_CHANNELS);
	localparam int MAX_AUX      = 3;
	localparam int AUX_COUNT    = (NUM_CHANNELS - 2 < MAX_AUX) ? (NUM_CHANNELS - 2) : MAX_AUX;

	localparam int CMD_W   = 3;
	localparam int LEN_W   = 8;
	localparam int BYTE_W  = 8;
	localparam int TIME_W  = 32;
	localparam int OUTCH_W = 3;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [BYTE_W-1:0] RESET_MAGIC   = 8'h42;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;
	localparam logic [CH_W-1:0]   CH_MAIN       = CH_W'(0);
	localparam logic [CH_W-1:0]   CH_DROGUE     = CH_W'(1);
	localparam logic [CH_W-1:0]   CH_AUX1       = CH_W'(2);

	// register indexes, taken from paddr[2]
	localparam logic REG_ARM_TIMEOUT = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_ARM_MAIN    = 3'd0,
		CMD_ARM_DROGUE  = 3'd1,
		CMD_ARM_AUX     = 3'd2,
		CMD_FIRE_MAIN   = 3'd3,
		CMD_FIRE_DROGUE = 3'd4,
		CMD_FIRE_AUX    = 3'd5,
		CMD_RESET       = 3'd6,
		CMD_IGNORE      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic                fire;
		logic [OUTCH_W-1:0]  fire_channel;
		logic                reset_request;
	} result_t;

	function automatic logic [CH_W-1:0] aux_channel(
		input logic [LEN_W-1:0]  len,
		input logic [BYTE_W-1:0] first
	);
		logic [BYTE_W-1:0] sum;
		sum = BYTE_W'(2) + first;
		if (len == LEN_W'(1) && first < BYTE_W'(AUX_COUNT)) begin
			return sum[CH_W-1:0];
		end
		return CH_AUX1;
	endfunction

endpackage

[sv/pafc_regs.sv]
// ----------------------------------------------------------------------------
// pafc_regs
// APB-style configuration register holding the firing window.
// ----------------------------------------------------------------------------
module pafc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pafc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pafc_pkg::DATA_W-1:0]   pwdata,
	output logic [pafc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [pafc_pkg::TIME_W-1:0]   arm_timeout_ms
);

	logic [pafc_pkg::TIME_W-1:0] timeout_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && paddr[2] == pafc_pkg::REG_ARM_TIMEOUT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= pafc_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			timeout_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pafc_pkg::REG_ARM_TIMEOUT) begin
			prdata = timeout_q;
		end
	end

	assign arm_timeout_ms = timeout_q;

endmodule

[sv/pafc_bank.sv]
// ----------------------------------------------------------------------------
// pafc_bank
// Per-channel armed flags and arm times, with the arm/fire decision.
// ----------------------------------------------------------------------------
module pafc_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [pafc_pkg::CMD_W-1:0]    cmd,
	input  logic [pafc_pkg::LEN_W-1:0]    msg_len,
	input  logic [pafc_pkg::BYTE_W-1:0]   payload_first,
	input  logic [pafc_pkg::TIME_W-1:0]   now_ms,
	input  logic [pafc_pkg::TIME_W-1:0]   arm_timeout_ms,
	output pafc_pkg::result_t             result
);

	logic                        armed_q [pafc_pkg::NUM_CHANNELS];
	logic [pafc_pkg::TIME_W-1:0] arm_time_q [pafc_pkg::NUM_CHANNELS];

	pafc_pkg::cmd_t              cmd_e;
	logic [pafc_pkg::CH_W-1:0]   ch;
	logic                        do_arm;
	logic                        do_fire;
	logic [pafc_pkg::TIME_W-1:0] elapsed;

	assign cmd_e = pafc_pkg::cmd_t'(cmd);

	always_comb begin
		ch      = pafc_pkg::CH_MAIN;
		do_arm  = 1'b0;
		do_fire = 1'b0;
		case (cmd_e)
			pafc_pkg::CMD_ARM_MAIN: begin
				ch     = pafc_pkg::CH_MAIN;
				do_arm = 1'b1;
			end
			pafc_pkg::CMD_ARM_DROGUE: begin
				ch     = pafc_pkg::CH_DROGUE;
				do_arm = 1'b1;
			end
			pafc_pkg::CMD_ARM_AUX: begin
				ch     = pafc_pkg::aux_channel(msg_len, payload_first);
				do_arm = 1'b1;
			end
			pafc_pkg::CMD_FIRE_MAIN: begin
				ch      = pafc_pkg::CH_MAIN;
				do_fire = 1'b1;
			end
			pafc_pkg::CMD_FIRE_DROGUE: begin
				ch      = pafc_pkg::CH_DROGUE;
				do_fire = 1'b1;
			end
			pafc_pkg::CMD_FIRE_AUX: begin
				ch      = pafc_pkg::aux_channel(msg_len, payload_first);
				do_fire = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// wraps modulo 2^32
	assign elapsed = now_ms - arm_time_q[ch];

	always_comb begin
		result               = '0;
		result.fire          = do_fire && armed_q[ch] && elapsed < arm_timeout_ms;
		result.fire_channel  = result.fire ? pafc_pkg::OUTCH_W'(ch) : '0;
		result.reset_request = cmd_e == pafc_pkg::CMD_RESET
			&& msg_len == pafc_pkg::LEN_W'(1)
			&& payload_first == pafc_pkg::RESET_MAGIC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pafc_pkg::NUM_CHANNELS; i++) begin
				armed_q[i] <= 1'b0;
			end
		end else if (go && do_arm) begin
			armed_q[ch] <= 1'b1;
		end
	end

	// times are only read behind a set armed flag
	always_ff @(posedge clk) begin
		if (go && do_arm) begin
			arm_time_q[ch] <= now_ms;
		end
	end

endmodule

[sv/pyro_arm_fire_controller_core.sv]
// ----------------------------------------------------------------------------
// pyro_arm_fire_controller_core
// Arms and fires five pyro channels from decoded radio commands.
// ----------------------------------------------------------------------------
// Each command beat is captured in an input register, decided against the
// channel's armed flag and arm time, and its single result beat then lands in an
// output register. One command can be accepted every cycle unless in_stall is
// raised; the throughput is set by the compare and update of the channel bank,
// and an output stall only holds the input side once both registers are full.
// The firing window is written at byte address 0 of the configuration port and
// may be changed only while no command is in flight.
module pyro_arm_fire_controller_core (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pafc_pkg::ADDR_W-1:0]   paddr,
	input  logic [pafc_pkg::DATA_W-1:0]   pwdata,
	output logic [pafc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pafc_pkg::CMD_W-1:0]    cmd,
	input  logic [pafc_pkg::LEN_W-1:0]    msg_len,
	input  logic [pafc_pkg::BYTE_W-1:0]   payload_first,
	input  logic [pafc_pkg::TIME_W-1:0]   now_ms,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          fire,
	output logic [pafc_pkg::OUTCH_W-1:0]  fire_channel,
	output logic                          reset_request
);

	logic [pafc_pkg::TIME_W-1:0] arm_timeout_ms;

	logic                        valid_s1;
	logic [pafc_pkg::CMD_W-1:0]  cmd_s1;
	logic [pafc_pkg::LEN_W-1:0]  len_s1;
	logic [pafc_pkg::BYTE_W-1:0] first_s1;
	logic [pafc_pkg::TIME_W-1:0] now_s1;

	logic                        valid_s2;
	pafc_pkg::result_t           result_s2;
	pafc_pkg::result_t           result;

	logic                        adv_s2;
	logic                        load_s1;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign load_s1  = in_valid && !in_stall;

	pafc_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.arm_timeout_ms (arm_timeout_ms)
	);

	pafc_bank u_bank (
		.clk            (clk),
		.arst_n         (arst_n),
		.go             (adv_s2),
		.cmd            (cmd_s1),
		.msg_len        (len_s1),
		.payload_first  (first_s1),
		.now_ms         (now_s1),
		.arm_timeout_ms (arm_timeout_ms),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd;
			len_s1   <= msg_len;
			first_s1 <= payload_first;
			now_s1   <= now_ms;
		end
		if (adv_s2) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign fire          = result_s2.fire;
	assign fire_channel  = result_s2.fire_channel;
	assign reset_request = result_s2.reset_request;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pyro arm/fire controller core. Command beats go
// in bursts with random gaps while the result side stalls on its own pattern;
// a behavioral copy of the channel bank predicts every outcome in order.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_HALF   = 6;
	localparam int RUN_LIMIT  = 6000000;
	localparam int SETTLE_CYC = 6;
	localparam int AUX_LIMIT  = 3;
	localparam int PHASE_CMDS = 220;
	localparam int NUM_PHASES = 5;
	localparam logic [pafc_pkg::ADDR_W-1:0] ADDR_ARM_TIMEOUT =
		{pafc_pkg::REG_ARM_TIMEOUT, 2'b00};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HALF,
		STALL_RARE,
		STALL_LONG
	} stall_mode_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [pafc_pkg::ADDR_W-1:0]         paddr;
	logic [pafc_pkg::DATA_W-1:0]         pwdata;
	logic [pafc_pkg::DATA_W-1:0]         prdata;
	logic                                pready;
	logic                                in_valid;
	logic                                in_stall;
	logic [pafc_pkg::CMD_W-1:0]          cmd;
	logic [pafc_pkg::LEN_W-1:0]          msg_len;
	logic [pafc_pkg::BYTE_W-1:0]         payload_first;
	logic [pafc_pkg::TIME_W-1:0]         now_ms;
	logic                                out_valid;
	logic                                out_stall;
	logic                                fire;
	logic [pafc_pkg::OUTCH_W-1:0]        fire_channel;
	logic                                reset_request;

	// channel bank copy and firing window
	logic [pafc_pkg::TIME_W-1:0]         window_ms;
	logic                                armed [pafc_pkg::NUM_CHANNELS];
	logic [pafc_pkg::TIME_W-1:0]         armed_at [pafc_pkg::NUM_CHANNELS];
	pafc_pkg::result_t                   decisions_q [$];

	logic [pafc_pkg::TIME_W-1:0]         clock_ms;
	int                                  burst_left = 0;
	int                                  n_errors   = 0;
	int                                  n_cmds     = 0;
	int                                  n_fires    = 0;
	int                                  n_resets   = 0;
	int                                  n_windows  = 0;

	stall_mode_t                         stall_mode = STALL_NONE;
	int                                  mode_left  = 0;
	int                                  hold_left  = 0;
	logic                                long_stall = 1'b0;

	pyro_arm_fire_controller_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic int channel_for(pafc_pkg::cmd_t c,
			logic [pafc_pkg::LEN_W-1:0] len, logic [pafc_pkg::BYTE_W-1:0] first);
		int aux_n;
		aux_n = (pafc_pkg::NUM_CHANNELS - 2 < AUX_LIMIT) ?
			pafc_pkg::NUM_CHANNELS - 2 : AUX_LIMIT;
		case (c)
			pafc_pkg::CMD_ARM_MAIN, pafc_pkg::CMD_FIRE_MAIN:
				return int'(pafc_pkg::CH_MAIN);
			pafc_pkg::CMD_ARM_DROGUE, pafc_pkg::CMD_FIRE_DROGUE:
				return int'(pafc_pkg::CH_DROGUE);
			default: begin
				if (len == pafc_pkg::LEN_W'(1) && int'(first) < aux_n)
					return int'(pafc_pkg::CH_AUX1) + int'(first);
				return int'(pafc_pkg::CH_AUX1);
			end
		endcase
	endfunction

	function automatic pafc_pkg::result_t decide_command(pafc_pkg::cmd_t c,
			logic [pafc_pkg::LEN_W-1:0] len, logic [pafc_pkg::BYTE_W-1:0] first,
			logic [pafc_pkg::TIME_W-1:0] t);
		pafc_pkg::result_t r;
		int ch;
		logic [pafc_pkg::TIME_W-1:0] elapsed;
		r = '0;
		ch = channel_for(c, len, first);
		case (c)
			pafc_pkg::CMD_ARM_MAIN, pafc_pkg::CMD_ARM_DROGUE, pafc_pkg::CMD_ARM_AUX: begin
				armed[ch] = 1'b1;
				armed_at[ch] = t;
			end
			pafc_pkg::CMD_FIRE_MAIN, pafc_pkg::CMD_FIRE_DROGUE,
			pafc_pkg::CMD_FIRE_AUX: begin
				// wraps modulo 2^32, firing leaves the channel armed
				elapsed = t - armed_at[ch];
				if (armed[ch] && elapsed < window_ms) begin
					r.fire = 1'b1;
					r.fire_channel = pafc_pkg::OUTCH_W'(ch);
				end
			end
			pafc_pkg::CMD_RESET:
				r.reset_request = (len == pafc_pkg::LEN_W'(1) && first == pafc_pkg::RESET_MAGIC);
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_cmd(input pafc_pkg::cmd_t c, input logic [pafc_pkg::LEN_W-1:0] len,
			input logic [pafc_pkg::BYTE_W-1:0] first, input logic [pafc_pkg::TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd           <= c;
		msg_len       <= len;
		payload_first <= first;
		now_ms        <= t;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		decisions_q.push_back(decide_command(c, len, first, t));
		n_cmds++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (decisions_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic read_window(output logic [pafc_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_ARM_TIMEOUT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input logic [pafc_pkg::TIME_W-1:0] value);
		logic [pafc_pkg::DATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ARM_TIMEOUT;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		window_ms = value;
		n_windows++;
		read_window(rd);
		if (rd !== value) begin
			$error("arm_timeout_ms: expected %0d, got %0d", value, rd);
			n_errors++;
		end
	endtask

	task automatic test_window_register();
		logic [pafc_pkg::DATA_W-1:0] rd;
		read_window(rd);
		if (rd !== pafc_pkg::TIMEOUT_RESET) begin
			$error("arm_timeout_ms: expected %0d, got %0d", pafc_pkg::TIMEOUT_RESET, rd);
			n_errors++;
		end
	endtask

	task automatic test_directed_commands();
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'd5);
		send_cmd(pafc_pkg::CMD_ARM_MAIN, 8'd0, 8'd0, 32'd100);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'd100);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'd10099);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'd10100);
		// window across the timestamp wrap
		send_cmd(pafc_pkg::CMD_ARM_DROGUE, 8'd254, 8'hff, 32'hffff_ff00);
		send_cmd(pafc_pkg::CMD_FIRE_DROGUE, 8'd254, 8'hff, 32'h0000_0010);
		send_cmd(pafc_pkg::CMD_FIRE_DROGUE, 8'd0, 8'd0, 32'hffff_feff);
		send_cmd(pafc_pkg::CMD_ARM_AUX, 8'd1, 8'd0, 32'd1000);
		send_cmd(pafc_pkg::CMD_ARM_AUX, 8'd1, 8'd1, 32'd2000);
		send_cmd(pafc_pkg::CMD_ARM_AUX, 8'd1, 8'd2, 32'd3000);
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd1, 8'd2, 32'd3001);
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd1, 8'd1, 32'd3001);
		// aux index out of range, empty and long payloads all fall back to aux 1
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd1, 8'd3, 32'd3001);
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd0, 8'd1, 32'd3001);
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd2, 8'd1, 32'd3001);
		send_cmd(pafc_pkg::CMD_ARM_AUX, 8'd254, 8'd2, 32'hffff_ffff);
		send_cmd(pafc_pkg::CMD_FIRE_AUX, 8'd1, 8'd0, 32'h0000_0000);
		send_cmd(pafc_pkg::CMD_RESET, 8'd1, pafc_pkg::RESET_MAGIC, 32'd0);
		send_cmd(pafc_pkg::CMD_RESET, 8'd2, pafc_pkg::RESET_MAGIC, 32'd0);
		send_cmd(pafc_pkg::CMD_RESET, 8'd1, 8'h43, 32'd0);
		send_cmd(pafc_pkg::CMD_RESET, 8'd0, pafc_pkg::RESET_MAGIC, 32'd0);
		send_cmd(pafc_pkg::CMD_IGNORE, 8'd1, pafc_pkg::RESET_MAGIC, 32'hffff_ffff);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd254, 8'hff, 32'hffff_ffff);
	endtask

	task automatic test_window_extremes();
		drain();
		set_window(32'd1);
		send_cmd(pafc_pkg::CMD_ARM_MAIN, 8'd0, 8'd0, 32'h8000_0000);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'h8000_0000);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'h8000_0001);
		drain();
		set_window(32'hffff_ffff);
		send_cmd(pafc_pkg::CMD_ARM_DROGUE, 8'd0, 8'd0, 32'd50);
		send_cmd(pafc_pkg::CMD_FIRE_DROGUE, 8'd0, 8'd0, 32'd49);
		send_cmd(pafc_pkg::CMD_FIRE_DROGUE, 8'd0, 8'd0, 32'd48);
		// zero window: nothing fires even right after arming
		drain();
		set_window(32'd0);
		send_cmd(pafc_pkg::CMD_FIRE_DROGUE, 8'd0, 8'd0, 32'd50);
		send_cmd(pafc_pkg::CMD_ARM_MAIN, 8'd0, 8'd0, 32'd7);
		send_cmd(pafc_pkg::CMD_FIRE_MAIN, 8'd0, 8'd0, 32'd7);
		drain();
		set_window(pafc_pkg::TIMEOUT_RESET);
	endtask

	task automatic send_random_cmd();
		int pick;
		int ch;
		pafc_pkg::cmd_t c;
		logic [pafc_pkg::LEN_W-1:0] len;
		logic [pafc_pkg::BYTE_W-1:0] first;
		logic [pafc_pkg::TIME_W-1:0] t;
		pick = $urandom_range(0, 99);
		len = pafc_pkg::LEN_W'($urandom_range(0, 254));
		first = pafc_pkg::BYTE_W'($urandom);
		clock_ms += $urandom_range(0, 50);
		t = clock_ms;
		if (pick < 70) begin
			if (pick < 28)
				c = pafc_pkg::cmd_t'(pafc_pkg::CMD_W'(int'(pafc_pkg::CMD_ARM_MAIN)
					+ $urandom_range(0, 2)));
			else
				c = pafc_pkg::cmd_t'(pafc_pkg::CMD_W'(int'(pafc_pkg::CMD_FIRE_MAIN)
					+ $urandom_range(0, 2)));
			if ((c == pafc_pkg::CMD_ARM_AUX || c == pafc_pkg::CMD_FIRE_AUX)
					&& $urandom_range(0, 9) < 7) begin
				len = pafc_pkg::LEN_W'(1);
				first = pafc_pkg::BYTE_W'($urandom_range(0, AUX_LIMIT));
			end
			if (pick >= 28) begin
				// aim at the edges of the channel's window, or inside it, or at random
				ch = channel_for(c, len, first);
				case ($urandom_range(0, 5))
					0: t = armed_at[ch] + window_ms - 1;
					1: t = armed_at[ch] + window_ms;
					2: t = armed_at[ch] + window_ms + 1;
					3: t = armed_at[ch] + ((window_ms == 0) ? 0 : $urandom % window_ms);
					4: t = $urandom;
					default: ;
				endcase
			end
		end else if (pick < 82) begin
			c = pafc_pkg::CMD_RESET;
			if ($urandom_range(0, 9) < 6) begin
				len = pafc_pkg::LEN_W'(1);
				first = pafc_pkg::RESET_MAGIC;
			end else if ($urandom_range(0, 1) == 1) begin
				len = pafc_pkg::LEN_W'(1);
			end
		end else if (pick < 88) begin
			c = pafc_pkg::CMD_IGNORE;
		end else begin
			c = pafc_pkg::cmd_t'(pafc_pkg::CMD_W'($urandom_range(0, 7)));
			t = $urandom;
		end
		send_cmd(c, len, first, t);
	endtask

	task automatic test_random_traffic();
		logic [pafc_pkg::TIME_W-1:0] w;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: w = $urandom_range(1, 64);
				1: w = pafc_pkg::TIMEOUT_RESET;
				2: w = 32'hffff_ffff;
				3: w = $urandom | 32'h1;
				default: w = $urandom_range(1000, 100000);
			endcase
			drain();
			set_window(w);
			clock_ms = $urandom;
			repeat (PHASE_CMDS) send_random_cmd();
		end
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
		end
		mode_left--;
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
			STALL_RARE: out_stall <= ($urandom_range(0, 7) == 0);
			default: begin
				if (hold_left == 0) begin
					long_stall = ~long_stall;
					hold_left = $urandom_range(1, 20);
				end
				hold_left--;
				out_stall <= long_stall;
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		pafc_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decisions_q.size() == 0) begin
				$error("result beat with no command outstanding");
				n_errors++;
			end else begin
				want = decisions_q.pop_front();
				if (want.fire)
					n_fires++;
				if (want.reset_request)
					n_resets++;
				if (fire !== want.fire) begin
					$error("fire: expected %0d, got %0d", want.fire, fire);
					n_errors++;
				end
				if (fire_channel !== want.fire_channel) begin
					$error("fire_channel: expected %0d, got %0d", want.fire_channel,
						fire_channel);
					n_errors++;
				end
				if (reset_request !== want.reset_request) begin
					$error("reset_request: expected %0d, got %0d", want.reset_request,
						reset_request);
					n_errors++;
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		cmd           = pafc_pkg::CMD_IGNORE;
		msg_len       = '0;
		payload_first = '0;
		now_ms        = '0;
		out_stall     = 1'b0;
		clock_ms      = '0;
		window_ms     = pafc_pkg::TIMEOUT_RESET;
		for (int i = 0; i < pafc_pkg::NUM_CHANNELS; i++) begin
			armed[i] = 1'b0;
			armed_at[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_register();
		test_directed_commands();
		test_window_extremes();
		test_random_traffic();
		drain();

		$display("checked %0d command beats across %0d firing window settings",
			n_cmds, n_windows);
		$display("%0d channel fires and %0d reset requests among them", n_fires, n_resets);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("run limit reached, %0d results outstanding", decisions_q.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
